### hw/rtl/speed_lock_target_interpolator_unit_macros.svh
// ----------------------------------------------------------------------------
// speed lock target interpolator assertion macros
// shared concurrent assertion forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SPEED_LOCK_TARGET_INTERPOLATOR_UNIT_MACROS_SVH
`define SPEED_LOCK_TARGET_INTERPOLATOR_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SLTI_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("slti same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SLTI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("slti next-cycle check failed");

`endif

### hw/rtl/slti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slti_pkg
// shared widths, codes and constants of the speed lock target interpolator
// ----------------------------------------------------------------------------
package slti_pkg;

    localparam int MAX_POINTS_DEFAULT = 16;

    // field widths
    localparam int SPEED_W  = 8;
    localparam int LOCK_W   = 7;
    localparam int PEDAL_W  = 7;
    localparam int RAW_W    = 8;
    localparam int INDEX_W  = 4;
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 5;
    localparam int TARGET_W = 15;
    localparam int ADJ_W    = 8;

    // configuration port
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_LOCK_MODE       = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PEDAL_THRESHOLD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT     = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CUSTOM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIFTY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FRONT  = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    localparam logic [MODE_W-1:0]  LOCK_MODE_RESET   = MODE_FRONT;
    localparam logic [PEDAL_W-1:0] THRESHOLD_RESET   = 7'd0;
    localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 5'd1;

    // target is percent with eight fraction bits
    localparam logic [TARGET_W-1:0] FULL_LOCK = 15'(100 * 256);
    // 20 percent base of the scale factor, in target units times two
    localparam logic [15:0] TARGET_BIAS = 16'(20 * 2 * 256);

    // raw * (t + bias) / 51200 = ((raw * (t + bias)) >> 11) / 25
    localparam int SCALE_W          = 24;
    localparam int SCALE_PRE_SHIFT  = 11;
    localparam int SCALE_POST_SHIFT = 17;
    localparam int SCALE_Y_W        = SCALE_W - SCALE_PRE_SHIFT;
    localparam int SCALE_P_W        = 2 * SCALE_Y_W;
    localparam logic [SCALE_Y_W-1:0] SCALE_RECIP = 13'd5243;

    // interpolation divide: (lock delta * speed delta) << 8 over speed span
    localparam int DIVIDEND_W = LOCK_W + SPEED_W + 8;
    localparam int DIVISOR_W  = SPEED_W;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [LOCK_W-1:0]  lock;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### hw/rtl/slti_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slti_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module slti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/slti_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slti_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module slti_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [slti_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [slti_pkg::DIVISOR_W-1:0]      divisor,
    output logic [slti_pkg::DIVIDEND_W-1:0]     quotient,
    output slti_pkg::div_status_t               status
);

    localparam int CNT_W = $clog2(slti_pkg::DIVIDEND_W + 1);

    logic [CNT_W-1:0]                     cnt_reg;
    logic                                 done_reg;
    logic [slti_pkg::DIVIDEND_W-1:0]      quo_reg;
    logic [slti_pkg::DIVISOR_W-1:0]       rem_reg;
    logic [slti_pkg::DIVISOR_W-1:0]       den_reg;

    logic [slti_pkg::DIVISOR_W:0]         rem_shift;
    logic                                 fits;
    logic [slti_pkg::DIVISOR_W-1:0]       rem_next;
    logic [slti_pkg::DIVIDEND_W-1:0]      quo_next;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[slti_pkg::DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, den_reg};
        rem_next  = fits ? slti_pkg::DIVISOR_W'(rem_shift - {1'b0, den_reg})
                         : rem_shift[slti_pkg::DIVISOR_W-1:0];
        quo_next  = {quo_reg[slti_pkg::DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(slti_pkg::DIVIDEND_W);
                quo_reg <= dividend;
                rem_reg <= '0;
                den_reg <= divisor;
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = cnt_reg != '0;
    assign status.done = done_reg;

endmodule

### hw/rtl/speed_lock_target_interpolator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speed_lock_target_interpolator_unit
// lockpoint table with piecewise linear lock target and drive scaling
// ----------------------------------------------------------------------------
// A lockpoint write gives no result. In fifty-fifty and front wheel
// mode an evaluate item goes straight to the finish state. In custom mode the
// table memory is read one entry per cycle until the first lockpoint at or
// above the road speed, or the last point in use, is reached. A clamped target
// then goes straight to scaling; an interpolated target first takes a multiply
// and the 23-step serial divider. One item is worked on at a time; a finished
// result sits in the output register while the next item is taken in. Table
// entries must be written before an evaluation reads them.
// ----------------------------------------------------------------------------
`include "speed_lock_target_interpolator_unit_macros.svh"

module speed_lock_target_interpolator_unit #(
    parameter int MAX_POINTS = slti_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [slti_pkg::PADDR_W-1:0]        paddr,
    input  logic [slti_pkg::PDATA_W-1:0]        pwdata,
    output logic [slti_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [slti_pkg::INDEX_W-1:0]        s_point_index,
    input  logic [slti_pkg::SPEED_W-1:0]        s_point_speed,
    input  logic [slti_pkg::LOCK_W-1:0]         s_point_lock,
    input  logic [slti_pkg::SPEED_W-1:0]        s_road_speed,
    input  logic [slti_pkg::PEDAL_W-1:0]        s_pedal,
    input  logic [slti_pkg::RAW_W-1:0]          s_raw_value,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [slti_pkg::TARGET_W-1:0]       m_lock_target,
    output logic [slti_pkg::ADJ_W-1:0]          m_adjusted_value
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int EW = $bits(slti_pkg::entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SCALE_MUL,
        ST_SCALE_DIV,
        ST_FINISH
    } state_t;

    // configuration registers
    logic [slti_pkg::MODE_W-1:0]   lock_mode_reg;
    logic [slti_pkg::PEDAL_W-1:0]  pedal_threshold_reg;
    logic [slti_pkg::COUNT_W-1:0]  point_count_reg;
    logic                          cfg_wr;

    state_t                        state_reg;
    logic [AW-1:0]                 idx_reg;
    logic [slti_pkg::SPEED_W-1:0]  speed_reg;
    logic                          pass_reg;
    logic [slti_pkg::RAW_W-1:0]    raw_reg;
    slti_pkg::entry_t              prev_reg;
    logic [slti_pkg::LOCK_W-1:0]   ll_reg;
    logic                          neg_reg;
    logic [slti_pkg::LOCK_W-1:0]   mag_reg;
    logic [slti_pkg::SPEED_W-1:0]  dv_reg;
    logic [slti_pkg::SPEED_W-1:0]  den_reg;
    logic [slti_pkg::LOCK_W+slti_pkg::SPEED_W-1:0] prod_reg;
    logic [slti_pkg::TARGET_W-1:0] target_reg;
    logic [slti_pkg::SCALE_W-1:0]  scale_reg;
    logic [slti_pkg::ADJ_W-1:0]    adj_reg;
    logic                          m_valid_reg;
    logic [slti_pkg::TARGET_W-1:0] m_lock_target_reg;
    logic [slti_pkg::ADJ_W-1:0]    m_adjusted_value_reg;

    logic                          accept;
    logic                          pass;
    logic [NW-1:0]                 n_eff;
    logic [AW-1:0]                 last_idx;
    slti_pkg::entry_t              cur;
    logic                          hit;
    logic                          last;
    logic [slti_pkg::SPEED_W:0]    diff;
    logic                          ram_we;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [EW-1:0]                 ram_rdata;
    logic                          div_start;
    logic [slti_pkg::DIVIDEND_W-1:0] div_quotient;
    slti_pkg::div_status_t         div_status;
    logic [slti_pkg::TARGET_W-1:0] interp_target;
    logic [15:0]                   biased;
    logic [slti_pkg::SCALE_P_W-1:0] recip_prod;
    logic                          out_free;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_mode_reg       <= slti_pkg::LOCK_MODE_RESET;
            pedal_threshold_reg <= slti_pkg::THRESHOLD_RESET;
            point_count_reg     <= slti_pkg::POINT_COUNT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[slti_pkg::REG_IDX_W+1:2])
                slti_pkg::REG_LOCK_MODE: begin
                    lock_mode_reg <= pwdata[slti_pkg::MODE_W-1:0];
                end
                slti_pkg::REG_PEDAL_THRESHOLD: begin
                    pedal_threshold_reg <= pwdata[slti_pkg::PEDAL_W-1:0];
                end
                slti_pkg::REG_POINT_COUNT: begin
                    point_count_reg <= pwdata[slti_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[slti_pkg::REG_IDX_W+1:2])
            slti_pkg::REG_LOCK_MODE:       prdata = slti_pkg::PDATA_W'(lock_mode_reg);
            slti_pkg::REG_PEDAL_THRESHOLD: prdata = slti_pkg::PDATA_W'(pedal_threshold_reg);
            slti_pkg::REG_POINT_COUNT:     prdata = slti_pkg::PDATA_W'(point_count_reg);
            default:                       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // scan control
    // ------------------------------------------------------------------
    assign s_ready = state_reg == ST_IDLE;
    assign accept  = s_valid && s_ready;
    assign pass    = s_pedal >= pedal_threshold_reg;

    // points in use: zero counts as one, saturate at table size
    always_comb begin
        if (point_count_reg == '0) begin
            n_eff = NW'(1);
        end else if (32'(point_count_reg) > 32'(MAX_POINTS)) begin
            n_eff = NW'(MAX_POINTS);
        end else begin
            n_eff = NW'(point_count_reg);
        end
        last_idx = AW'(n_eff - NW'(1));
    end

    assign cur  = slti_pkg::entry_t'(ram_rdata);
    assign hit  = speed_reg <= cur.speed;
    assign last = idx_reg == last_idx;
    assign diff = {2'b00, cur.lock} - {2'b00, prev_reg.lock};

    assign ram_we = accept && (s_func == slti_pkg::FUNC_WRITE)
                    && (32'(s_point_index) < 32'(MAX_POINTS));
    assign ram_re = (accept && (s_func == slti_pkg::FUNC_EVAL)
                     && (lock_mode_reg == slti_pkg::MODE_CUSTOM))
                    || ((state_reg == ST_SCAN) && !hit && !last);
    assign ram_raddr = (state_reg == ST_IDLE) ? '0 : idx_reg + AW'(1);

    slti_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(s_point_index)),
        .wr_data ({s_point_speed, s_point_lock}),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign div_start = state_reg == ST_DIV_START;

    slti_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({prod_reg, 8'h00}),
        .divisor  (den_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // quotient stays below the lock span, so it fits the target width
    assign interp_target = neg_reg
        ? {ll_reg, 8'h00} - div_quotient[slti_pkg::TARGET_W-1:0]
        : {ll_reg, 8'h00} + div_quotient[slti_pkg::TARGET_W-1:0];

    assign biased     = 16'(target_reg) + slti_pkg::TARGET_BIAS;
    assign recip_prod = {{slti_pkg::SCALE_Y_W{1'b0}},
                         scale_reg[slti_pkg::SCALE_W-1:slti_pkg::SCALE_PRE_SHIFT]}
                        * {{slti_pkg::SCALE_Y_W{1'b0}}, slti_pkg::SCALE_RECIP};

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_func == slti_pkg::FUNC_EVAL)) begin
                        speed_reg <= s_road_speed;
                        pass_reg  <= pass;
                        raw_reg   <= s_raw_value;
                        idx_reg   <= '0;
                        unique case (lock_mode_reg)
                            slti_pkg::MODE_CUSTOM: begin
                                state_reg <= ST_SCAN;
                            end
                            slti_pkg::MODE_FIFTY: begin
                                target_reg <= pass ? slti_pkg::FULL_LOCK : '0;
                                adj_reg    <= pass ? s_raw_value : '0;
                                state_reg  <= ST_FINISH;
                            end
                            default: begin
                                target_reg <= '0;
                                adj_reg    <= '0;
                                state_reg  <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (hit || last) begin
                        // a hit past slot zero has the previous point strictly below
                        if (!hit || (idx_reg == '0) || (speed_reg == cur.speed)) begin
                            target_reg <= {cur.lock, 8'h00};
                            state_reg  <= ST_SCALE_MUL;
                        end else if (!pass_reg) begin
                            target_reg <= '0;
                            state_reg  <= ST_SCALE_MUL;
                        end else begin
                            ll_reg    <= prev_reg.lock;
                            neg_reg   <= diff[slti_pkg::SPEED_W];
                            mag_reg   <= diff[slti_pkg::SPEED_W]
                                         ? slti_pkg::LOCK_W'(-diff)
                                         : slti_pkg::LOCK_W'(diff);
                            dv_reg    <= speed_reg - prev_reg.speed;
                            den_reg   <= cur.speed - prev_reg.speed;
                            state_reg <= ST_MUL;
                        end
                    end else begin
                        prev_reg <= cur;
                        idx_reg  <= idx_reg + AW'(1);
                    end
                end
                ST_MUL: begin
                    prod_reg  <= {{slti_pkg::SPEED_W{1'b0}}, mag_reg}
                                 * {{slti_pkg::LOCK_W{1'b0}}, dv_reg};
                    state_reg <= ST_DIV_START;
                end
                ST_DIV_START: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_status.done) begin
                        target_reg <= interp_target;
                        state_reg  <= ST_SCALE_MUL;
                    end
                end
                ST_SCALE_MUL: begin
                    scale_reg <= {{(slti_pkg::SCALE_W - slti_pkg::RAW_W){1'b0}}, raw_reg}
                                 * {{(slti_pkg::SCALE_W - 16){1'b0}}, biased};
                    state_reg <= ST_SCALE_DIV;
                end
                ST_SCALE_DIV: begin
                    adj_reg   <= (target_reg == '0) ? '0
                                 : recip_prod[slti_pkg::SCALE_POST_SHIFT +: slti_pkg::ADJ_W];
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg          <= 1'b1;
                        m_lock_target_reg    <= target_reg;
                        m_adjusted_value_reg <= adj_reg;
                        state_reg            <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_lock_target    = m_lock_target_reg;
    assign m_adjusted_value = m_adjusted_value_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SLTI_ASSERT_SAME(a_no_accept_in_divide, aclk, aresetn, s_valid && s_ready, !div_status.busy)
    `SLTI_ASSERT_SAME(a_scan_in_range, aclk, aresetn, state_reg == ST_SCAN, idx_reg <= last_idx)
    `SLTI_ASSERT_SAME(a_target_max, aclk, aresetn, m_valid, m_lock_target <= slti_pkg::FULL_LOCK)
    `SLTI_ASSERT_NEXT(a_divide_to_scale, aclk, aresetn, div_status.done, state_reg == ST_SCALE_MUL)

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the speed lock target interpolator. A short list of directed rows
// covers the lock modes, the pedal threshold, the table end clamps and the
// point count limits. Random lockpoint writes and evaluations follow under
// changing register settings and random handshake stalls. Every result is
// compared with a typed expected value or an in-bench prediction of the lock
// target and the scaled drive value.
// ----------------------------------------------------------------------------
module testbench;
    import slti_pkg::*;

    localparam int CLK_PERIOD         = 10;
    localparam int RESET_CYCLES       = 4;
    localparam int TABLE_DEPTH        = MAX_POINTS_DEFAULT;
    localparam int SETTLE_CYCLES      = 64;
    localparam int WATCHDOG_LIMIT     = 4000;
    localparam int SEGMENTS_PER_PHASE = 8;
    localparam int ITEMS_PER_SEGMENT  = 40;
    localparam int MAX_REPORTS        = 40;
    localparam int Q8_ONE             = 256;
    localparam int SCALE_DIV          = 2 * int'(FULL_LOCK);
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic EXPECT_MODEL = 1'b0;
    localparam logic EXPECT_TYPED = 1'b1;

    typedef struct packed {
        logic               func;
        logic [INDEX_W-1:0] point_index;
        logic [SPEED_W-1:0] point_speed;
        logic [LOCK_W-1:0]  point_lock;
        logic [SPEED_W-1:0] road_speed;
        logic [PEDAL_W-1:0] pedal;
        logic [RAW_W-1:0]   raw_value;
    } lock_item_t;

    typedef struct packed {
        logic [TARGET_W-1:0] lock_target;
        logic [ADJ_W-1:0]    adjusted_value;
    } lock_result_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [REG_IDX_W-1:0]   reg_idx;
        logic [PDATA_W-1:0]     reg_val;
        lock_item_t             item;
        logic                   typed;
        lock_result_t           want;
    } dir_row_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_W-1:0]    paddr   = '0;
    logic [PDATA_W-1:0]    pwdata  = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic                  s_func        = FUNC_WRITE;
    logic [INDEX_W-1:0]    s_point_index = '0;
    logic [SPEED_W-1:0]    s_point_speed = '0;
    logic [LOCK_W-1:0]     s_point_lock  = '0;
    logic [SPEED_W-1:0]    s_road_speed  = '0;
    logic [PEDAL_W-1:0]    s_pedal       = '0;
    logic [RAW_W-1:0]      s_raw_value   = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [TARGET_W-1:0]   m_lock_target;
    logic [ADJ_W-1:0]      m_adjusted_value;

    // shadow of the lockpoint table and the registers
    logic [SPEED_W-1:0] point_speed_tbl [TABLE_DEPTH];
    logic [LOCK_W-1:0]  point_lock_tbl [TABLE_DEPTH];
    logic [MODE_W-1:0]  cur_mode      = LOCK_MODE_RESET;
    logic [PEDAL_W-1:0] cur_threshold = THRESHOLD_RESET;
    logic [COUNT_W-1:0] cur_count     = POINT_COUNT_RESET;

    lock_result_t pending_lock_results [$];
    lock_result_t oldest_lock_result;
    dir_row_t     dir_rows [$];

    int src_idle_pct     = 0;
    int sink_stall_pct   = 0;
    int mismatches       = 0;
    int items_sent       = 0;
    int lockpoint_writes = 0;
    int results_checked  = 0;
    int reg_writes       = 0;
    int idle_cycles      = 0;
    int evals_by_mode [4] = '{0, 0, 0, 0};

    speed_lock_target_interpolator_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_point_index    (s_point_index),
        .s_point_speed    (s_point_speed),
        .s_point_lock     (s_point_lock),
        .s_road_speed     (s_road_speed),
        .s_pedal          (s_pedal),
        .s_raw_value      (s_raw_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_lock_target    (m_lock_target),
        .m_adjusted_value (m_adjusted_value)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
    endtask

    function automatic lock_result_t predict_lock_result(input lock_item_t it);
        lock_result_t res;
        int n, lo, hi, i, v, raw, sl, su, ll, lu, t;
        logic pass, found;
        pass = (it.pedal >= cur_threshold);
        raw  = it.raw_value;
        v    = it.road_speed;
        t    = 0;
        if (cur_mode == MODE_FIFTY) begin
            res.lock_target    = pass ? FULL_LOCK : '0;
            res.adjusted_value = pass ? it.raw_value : '0;
        end else begin
            if (cur_mode == MODE_CUSTOM) begin
                n = (cur_count == 0) ? 1 : (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_count;
                lo = 0;
                hi = n - 1;
                found = 1'b0;
                // first lockpoint at or above the road speed
                for (i = 0; i < n; i++) begin
                    if (!found && v <= point_speed_tbl[i]) begin
                        found = 1'b1;
                        hi = i;
                        lo = (i == 0) ? 0 : i - 1;
                    end
                end
                sl = point_speed_tbl[lo];
                su = point_speed_tbl[hi];
                ll = point_lock_tbl[lo];
                lu = point_lock_tbl[hi];
                if (v <= sl) begin
                    t = ll * Q8_ONE;
                end else if (v >= su) begin
                    t = lu * Q8_ONE;
                end else if (pass) begin
                    t = ll * Q8_ONE + ((lu - ll) * (v - sl) * Q8_ONE) / (su - sl);
                end
            end
            res.lock_target    = TARGET_W'(t);
            res.adjusted_value = (t == 0) ? '0 :
                                 ADJ_W'((raw * (t + int'(TARGET_BIAS))) / SCALE_DIV);
        end
        return res;
    endfunction

    task automatic send_item(input lock_item_t it, input logic typed, input lock_result_t want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= it.func;
        s_point_index <= it.point_index;
        s_point_speed <= it.point_speed;
        s_point_lock  <= it.point_lock;
        s_road_speed  <= it.road_speed;
        s_pedal       <= it.pedal;
        s_raw_value   <= it.raw_value;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (it.func == FUNC_WRITE) begin
            point_speed_tbl[it.point_index] = it.point_speed;
            point_lock_tbl[it.point_index]  = it.point_lock;
            lockpoint_writes++;
        end else begin
            pending_lock_results.push_back(typed ? want : predict_lock_result(it));
            evals_by_mode[cur_mode]++;
        end
    endtask

    // registers change only with the stream drained and the block quiet
    task automatic write_reg_when_idle(input logic [REG_IDX_W-1:0] idx,
                                       input logic [PDATA_W-1:0] val);
        s_valid <= 1'b0;
        while (pending_lock_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LOCK_MODE:       cur_mode      = val[MODE_W-1:0];
            REG_PEDAL_THRESHOLD: cur_threshold = val[PEDAL_W-1:0];
            REG_POINT_COUNT:     cur_count     = val[COUNT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    function automatic dir_row_t reg_row(input logic [REG_IDX_W-1:0] idx, input int val);
        dir_row_t row;
        row         = '0;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = PDATA_W'(val);
        return row;
    endfunction

    function automatic dir_row_t write_row(input int slot, input int spd, input int lck);
        dir_row_t row;
        row                  = '0;
        row.kind             = ROW_ITEM;
        row.item.func        = FUNC_WRITE;
        row.item.point_index = INDEX_W'(slot);
        row.item.point_speed = SPEED_W'(spd);
        row.item.point_lock  = LOCK_W'(lck);
        return row;
    endfunction

    function automatic dir_row_t eval_row(input int spd, input int ped, input int raw,
                                          input logic typed, input int tgt, input int adj);
        dir_row_t row;
        row                     = '0;
        row.kind                = ROW_ITEM;
        row.item.func           = FUNC_EVAL;
        row.item.road_speed     = SPEED_W'(spd);
        row.item.pedal          = PEDAL_W'(ped);
        row.item.raw_value      = RAW_W'(raw);
        row.typed               = typed;
        row.want.lock_target    = TARGET_W'(tgt);
        row.want.adjusted_value = ADJ_W'(adj);
        return row;
    endfunction

    // result side: random back-pressure and in-order compare
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (pending_lock_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected item: lock_target %0d adjusted_value %0d",
                                              m_lock_target, m_adjusted_value));
                end else begin
                    oldest_lock_result = pending_lock_results.pop_front();
                    if (m_lock_target !== oldest_lock_result.lock_target) begin
                        report_mismatch($sformatf("lock_target got %0d, expected %0d",
                                                  m_lock_target, oldest_lock_result.lock_target));
                    end
                    if (m_adjusted_value !== oldest_lock_result.adjusted_value) begin
                        report_mismatch($sformatf("adjusted_value got %0d, expected %0d",
                                                  m_adjusted_value,
                                                  oldest_lock_result.adjusted_value));
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin : main_flow
        lock_item_t   it;
        lock_result_t none;
        int k, phase, seg, n_use, idx, lo_s, hi_s, r, prev;
        none = '0;

        // after reset: front wheel only
        dir_rows.push_back(eval_row(255, 100, 255, EXPECT_TYPED, 0, 0));
        // fifty-fifty around the pedal threshold
        dir_rows.push_back(reg_row(REG_LOCK_MODE, MODE_FIFTY));
        dir_rows.push_back(reg_row(REG_PEDAL_THRESHOLD, 50));
        dir_rows.push_back(eval_row(128, 50, 255, EXPECT_TYPED, int'(FULL_LOCK), 255));
        dir_rows.push_back(eval_row(128, 49, 200, EXPECT_TYPED, 0, 0));
        dir_rows.push_back(reg_row(REG_PEDAL_THRESHOLD, 0));
        dir_rows.push_back(eval_row(0, 0, 0, EXPECT_TYPED, int'(FULL_LOCK), 0));
        dir_rows.push_back(reg_row(REG_PEDAL_THRESHOLD, 100));
        dir_rows.push_back(eval_row(255, 100, 1, EXPECT_TYPED, int'(FULL_LOCK), 1));
        // unused mode acts as front wheel only
        dir_rows.push_back(reg_row(REG_LOCK_MODE, MODE_UNUSED));
        dir_rows.push_back(eval_row(77, 100, 255, EXPECT_TYPED, 0, 0));
        // small table: lock rises, falls, then rises again
        dir_rows.push_back(write_row(0, 10, 0));
        dir_rows.push_back(write_row(1, 50, 100));
        dir_rows.push_back(write_row(2, 100, 30));
        dir_rows.push_back(write_row(3, 255, 100));
        dir_rows.push_back(reg_row(REG_LOCK_MODE, MODE_CUSTOM));
        dir_rows.push_back(reg_row(REG_POINT_COUNT, 4));
        dir_rows.push_back(reg_row(REG_PEDAL_THRESHOLD, 30));
        // clamps ignore the pedal, zero target gives zero drive
        dir_rows.push_back(eval_row(0, 0, 255, EXPECT_TYPED, 0, 0));
        dir_rows.push_back(eval_row(50, 0, 255, EXPECT_TYPED, int'(FULL_LOCK), 178));
        dir_rows.push_back(eval_row(255, 0, 100, EXPECT_TYPED, int'(FULL_LOCK), 70));
        dir_rows.push_back(eval_row(30, 30, 200, EXPECT_MODEL, 0, 0));
        dir_rows.push_back(eval_row(30, 29, 200, EXPECT_TYPED, 0, 0));
        dir_rows.push_back(eval_row(75, 100, 255, EXPECT_MODEL, 0, 0));
        dir_rows.push_back(eval_row(51, 100, 128, EXPECT_MODEL, 0, 0));
        // zero count behaves as one point
        dir_rows.push_back(reg_row(REG_POINT_COUNT, 0));
        dir_rows.push_back(eval_row(200, 100, 255, EXPECT_TYPED, 0, 0));
        // oversized count, speed below the first point
        dir_rows.push_back(reg_row(REG_POINT_COUNT, 31));
        dir_rows.push_back(eval_row(5, 0, 255, EXPECT_TYPED, 0, 0));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_REG) begin
                write_reg_when_idle(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            end else begin
                send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            src_idle_pct   = (phase == 0) ? 24 : (phase == 1) ? 45 : 0;
            sink_stall_pct = (phase == 0) ? 45 : (phase == 1) ? 24 : 0;
            for (seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
                r = $urandom_range(9);
                write_reg_when_idle(REG_LOCK_MODE, (r <= 5) ? MODE_CUSTOM :
                                    (r <= 7) ? MODE_FIFTY : (r == 8) ? MODE_FRONT : MODE_UNUSED);
                r = $urandom_range(5);
                write_reg_when_idle(REG_PEDAL_THRESHOLD, (r == 0) ? 0 : (r == 1) ? 100 :
                                    $urandom_range(100));
                r = $urandom_range(9);
                write_reg_when_idle(REG_POINT_COUNT, (r == 0) ? 0 :
                                    (r == 1) ? $urandom_range(31, 17) :
                                    (r == 2) ? TABLE_DEPTH : (r == 3) ? 1 :
                                    $urandom_range(TABLE_DEPTH, 2));

                // fresh sorted table; the first one fills every slot before any scan
                if ((phase == 0 && seg == 0) || $urandom_range(3) == 0) begin
                    prev = $urandom_range(20);
                    for (k = 0; k < TABLE_DEPTH; k++) begin
                        it             = '0;
                        it.func        = FUNC_WRITE;
                        it.point_index = INDEX_W'(k);
                        it.point_speed = SPEED_W'(prev);
                        it.point_lock  = LOCK_W'($urandom_range(100));
                        it.road_speed  = SPEED_W'($urandom_range(255));
                        it.pedal       = PEDAL_W'($urandom_range(100));
                        it.raw_value   = RAW_W'($urandom_range(255));
                        send_item(it, EXPECT_MODEL, none);
                        prev = prev + $urandom_range(24);
                        if (prev > 255) prev = 255;
                    end
                end

                for (k = 0; k < ITEMS_PER_SEGMENT; k++) begin
                    n_use = (cur_count == 0) ? 1 :
                            (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_count;
                    it.func        = ($urandom_range(99) < 15) ? FUNC_WRITE : FUNC_EVAL;
                    it.point_index = INDEX_W'($urandom_range(TABLE_DEPTH - 1));
                    it.point_speed = SPEED_W'($urandom_range(255));
                    it.point_lock  = LOCK_W'($urandom_range(100));
                    it.road_speed  = SPEED_W'($urandom_range(255));
                    it.pedal       = PEDAL_W'($urandom_range(100));
                    it.raw_value   = RAW_W'($urandom_range(255));
                    if (it.func == FUNC_WRITE) begin
                        // mostly keep speeds rising, sometimes break the order
                        if ($urandom_range(3) != 0) begin
                            idx  = it.point_index;
                            lo_s = (idx == 0) ? 0 : point_speed_tbl[idx - 1];
                            hi_s = (idx == TABLE_DEPTH - 1) ? 255 : point_speed_tbl[idx + 1];
                            it.point_speed = SPEED_W'($urandom_range(hi_s, lo_s));
                        end
                    end else begin
                        idx = $urandom_range(n_use - 1);
                        r   = $urandom_range(9);
                        if (r < 3) begin
                            it.road_speed = point_speed_tbl[idx];
                        end else if (r < 7 && idx > 0) begin
                            it.road_speed = SPEED_W'($urandom_range(point_speed_tbl[idx],
                                                                    point_speed_tbl[idx - 1]));
                        end
                        r = $urandom_range(9);
                        if (r < 3) begin
                            it.pedal = (r == 0 && cur_threshold > 0) ? cur_threshold - 1'b1 :
                                       cur_threshold;
                        end
                        if ($urandom_range(9) == 0) begin
                            it.raw_value = ($urandom_range(1) == 0) ? '0 : '1;
                        end
                    end
                    send_item(it, EXPECT_MODEL, none);
                end
            end
        end

        s_valid <= 1'b0;
        while (pending_lock_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("summary: %0d items in (%0d lockpoint writes), %0d results checked, %0d register writes",
                 items_sent, lockpoint_writes, results_checked, reg_writes);
        $display("summary: evaluations by mode: custom %0d, fifty-fifty %0d, front %0d, unused %0d",
                 evals_by_mode[0], evals_by_mode[1], evals_by_mode[2], evals_by_mode[3]);
        if (mismatches == 0 && pending_lock_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
